### rtl/differential_pid_duty_controller_macros.svh
// ----------------------------------------------------------------------------
// differential pid duty controller - assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_PID_DUTY_CONTROLLER_MACROS_SVH
`define DIFFERENTIAL_PID_DUTY_CONTROLLER_MACROS_SVH

// same-cycle implication
`define DPDC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DPDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/dpdc_pkg.sv
// ----------------------------------------------------------------------------
// dpdc_pkg
// types, register indexes, reset values and the duty clamp
// ----------------------------------------------------------------------------
`default_nettype none

package dpdc_pkg;

   localparam int ERR_W       = 8;
   localparam int VAL_W       = ERR_W + 1;      // error, integral and difference
   localparam int GAIN_W      = 16;
   localparam int DUTY_W      = 16;
   localparam int FRAC_BITS   = 10;
   localparam int PROD_W      = GAIN_W + 1 + VAL_W;
   localparam int TOTAL_W     = PROD_W + 2;
   localparam int CORR_W      = 16;
   localparam int WIDE_W      = DUTY_W + 2;
   localparam int REG_COUNT   = 8;
   localparam int CSR_INDEX_W = $clog2(REG_COUNT);
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_P_LEFT  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_I_LEFT  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_D_LEFT  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_P_RIGHT = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_I_RIGHT = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_D_RIGHT = CSR_INDEX_W'(5);
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_SPEED   = CSR_INDEX_W'(6);
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPEED    = CSR_INDEX_W'(7);

   localparam logic [GAIN_W-1:0] RST_GAIN_P = 16'd1229;   // about 1.2 in q6.10
   localparam logic [GAIN_W-1:0] RST_GAIN_I = 16'd0;
   localparam logic [GAIN_W-1:0] RST_GAIN_D = 16'd10240;  // 10.0 in q6.10
   localparam logic [DUTY_W-1:0] RST_BASE   = 16'd0;
   localparam logic [DUTY_W-1:0] RST_MAX    = 16'hFFFF;

   typedef struct packed {
      logic [GAIN_W-1:0] p;
      logic [GAIN_W-1:0] i;
      logic [GAIN_W-1:0] d;
   } gain_set_type;

   typedef struct packed {
      gain_set_type      left;
      gain_set_type      right;
      logic [DUTY_W-1:0] base_speed;
      logic [DUTY_W-1:0] max_speed;
   } csr_type;

   // above max gives max, at or below zero gives one
   function automatic logic [DUTY_W-1:0] clamp_duty(
      input logic signed [WIDE_W-1:0] duty,
      input logic        [DUTY_W-1:0] max_speed
   );
      logic signed [WIDE_W-1:0] max_wide;
      max_wide = $signed({2'b00, max_speed});
      if (duty > max_wide) begin
         return max_speed;
      end else if (duty <= $signed(WIDE_W'(0))) begin
         return DUTY_W'(1);
      end else begin
         return duty[DUTY_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

### rtl/dpdc_ifs.sv
// ----------------------------------------------------------------------------
// dpdc request and response channels
// valid/ready channels carrying the position error and the duty pair
// ----------------------------------------------------------------------------
`default_nettype none

interface dpdc_req_if;
   import dpdc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ERR_W-1:0] position_error;

   modport source (output valid, output position_error, input ready);
   modport sink   (input valid, input position_error, output ready);
endinterface

interface dpdc_rsp_if;
   import dpdc_pkg::*;

   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_left;
   logic [DUTY_W-1:0] duty_right;

   modport source (output valid, output duty_left, output duty_right, input ready);
   modport sink   (input valid, input duty_left, input duty_right, output ready);
endinterface

`default_nettype wire

### rtl/differential_pid_duty_controller.sv
// ----------------------------------------------------------------------------
// differential_pid_duty_controller
// line-following pid with separate left and right gains, clamped duties
// ----------------------------------------------------------------------------
`default_nettype none
`include "differential_pid_duty_controller_macros.svh"

// Each request carries one signed 8-bit position error. On acceptance the
// wrapping 8-bit integral and the previous error are updated, and the error,
// the new integral and the difference against the previous error are
// captured in the input register. From there one pass of combinational logic
// forms the three gain products for each side, sums them, truncates the q.10
// total toward zero, forms base + left correction and base - right
// correction, clamps each to 1..max_speed and loads the response register.
// A request accepted at one clock edge passes through the input register and
// then the response register before its duties appear on rsp_chan. One
// request is accepted every cycle for as long as responses are taken; that
// rate is set by the two register stages (input and response), each of which
// advances whenever the stage after it is empty or moving. Up to two
// requests are in flight, so a request is still taken while a finished
// response waits. Registers must be written through the csr port only while
// the block is empty; the block itself does not enforce it.

module differential_pid_duty_controller (
   input  logic                              clock,
   input  logic                              reset,
   dpdc_req_if.sink                          req_chan,
   dpdc_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [dpdc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dpdc_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import dpdc_pkg::*;

   csr_type csr;

   // controller state
   logic signed [ERR_W-1:0] error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0] prev_error_ff, prev_error_in;

   // input register stage
   logic                    a_vld_ff, a_vld_in;
   logic signed [VAL_W-1:0] a_err_ff, a_sum_ff, a_diff_ff;
   logic signed [VAL_W-1:0] a_diff_in;

   // per-side corrections, straight from the input register
   logic signed [CORR_W-1:0] corr_left, corr_right;

   // response register
   logic                    out_vld_ff, out_vld_in;
   logic [DUTY_W-1:0]       duty_left_ff, duty_right_ff;
   logic signed [WIDE_W-1:0] raw_left, raw_right;

   // stage advance, back to front
   logic adv_a, adv_rsp;
   logic req_fire;

   assign adv_rsp  = !out_vld_ff || rsp_chan.ready;
   assign adv_a    = !a_vld_ff || adv_rsp;
   assign req_fire = req_chan.valid && adv_a;

   assign req_chan.ready = adv_a;

   dpdc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   // integral wraps modulo 256, difference needs the ninth bit
   assign error_sum_in  = req_fire ? error_sum_ff + req_chan.position_error : error_sum_ff;
   assign prev_error_in = req_fire ? req_chan.position_error : prev_error_ff;
   assign a_diff_in     = VAL_W'(req_chan.position_error) - VAL_W'(prev_error_ff);
   assign a_vld_in      = adv_a ? req_fire : a_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         prev_error_ff <= '0;
         a_vld_ff      <= 1'b0;
      end else begin
         error_sum_ff  <= error_sum_in;
         prev_error_ff <= prev_error_in;
         a_vld_ff      <= a_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_err_ff  <= VAL_W'(req_chan.position_error);
         a_sum_ff  <= VAL_W'(error_sum_in);
         a_diff_ff <= a_diff_in;
      end
   end

   dpdc_side u_side_left (
      .gains      (csr.left),
      .err        (a_err_ff),
      .err_sum    (a_sum_ff),
      .err_diff   (a_diff_ff),
      .correction (corr_left)
   );

   dpdc_side u_side_right (
      .gains      (csr.right),
      .err        (a_err_ff),
      .err_sum    (a_sum_ff),
      .err_diff   (a_diff_ff),
      .correction (corr_right)
   );

   // left adds its correction, right subtracts its own
   assign raw_left  = $signed({2'b00, csr.base_speed}) + WIDE_W'(corr_left);
   assign raw_right = $signed({2'b00, csr.base_speed}) - WIDE_W'(corr_right);

   assign out_vld_in = adv_rsp ? a_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_rsp && a_vld_ff) begin
         duty_left_ff  <= clamp_duty(raw_left, csr.max_speed);
         duty_right_ff <= clamp_duty(raw_right, csr.max_speed);
      end
   end

   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.duty_left  = duty_left_ff;
   assign rsp_chan.duty_right = duty_right_ff;

   // checks

   `DPDC_ASSERT_NEXT(a_state_hold, clock, reset, !req_fire,
      $stable(error_sum_ff) && $stable(prev_error_ff), "controller state moved without a request")

   `DPDC_ASSERT_NEXT(a_input_to_rsp, clock, reset, a_vld_ff && adv_rsp, out_vld_ff,
      "input register request did not reach the response register")

   `DPDC_ASSERT_NEXT(a_rsp_hold, clock, reset, out_vld_ff && !rsp_chan.ready,
      out_vld_ff && $stable(duty_left_ff) && $stable(duty_right_ff), "waiting response changed")

   `DPDC_ASSERT_NOW(a_duty_nonzero, clock, reset, out_vld_ff && csr.max_speed != '0,
      duty_left_ff != '0 && duty_right_ff != '0, "clamped duty is zero")

   `DPDC_ASSERT_NOW(a_duty_limit, clock, reset, out_vld_ff && csr.max_speed != '0,
      duty_left_ff <= csr.max_speed && duty_right_ff <= csr.max_speed,
      "clamped duty above max_speed")

endmodule

`default_nettype wire

### rtl/dpdc_csr.sv
// ----------------------------------------------------------------------------
// dpdc_csr
// gain, base and limit registers behind the plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module dpdc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [dpdc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dpdc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output dpdc_pkg::csr_type                 csr
);
   import dpdc_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_GAIN_P_LEFT:  csr_in.left.p     = csr_write_data;
            REG_GAIN_I_LEFT:  csr_in.left.i     = csr_write_data;
            REG_GAIN_D_LEFT:  csr_in.left.d     = csr_write_data;
            REG_GAIN_P_RIGHT: csr_in.right.p    = csr_write_data;
            REG_GAIN_I_RIGHT: csr_in.right.i    = csr_write_data;
            REG_GAIN_D_RIGHT: csr_in.right.d    = csr_write_data;
            REG_BASE_SPEED:   csr_in.base_speed = csr_write_data;
            REG_MAX_SPEED:    csr_in.max_speed  = csr_write_data;
            default:          csr_in            = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.left.p     <= RST_GAIN_P;
         csr_ff.left.i     <= RST_GAIN_I;
         csr_ff.left.d     <= RST_GAIN_D;
         csr_ff.right.p    <= RST_GAIN_P;
         csr_ff.right.i    <= RST_GAIN_I;
         csr_ff.right.d    <= RST_GAIN_D;
         csr_ff.base_speed <= RST_BASE;
         csr_ff.max_speed  <= RST_MAX;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

`default_nettype wire

### rtl/dpdc_side.sv
// ----------------------------------------------------------------------------
// dpdc_side
// one motor side: p, i and d products, summed and truncated toward zero
// into an integer correction
// ----------------------------------------------------------------------------
`default_nettype none

module dpdc_side (
   input  dpdc_pkg::gain_set_type                   gains,
   input  logic signed [dpdc_pkg::VAL_W-1:0]        err,
   input  logic signed [dpdc_pkg::VAL_W-1:0]        err_sum,
   input  logic signed [dpdc_pkg::VAL_W-1:0]        err_diff,
   output logic signed [dpdc_pkg::CORR_W-1:0]       correction
);
   import dpdc_pkg::*;

   logic signed [PROD_W-1:0]  prod_p, prod_i, prod_d;
   logic signed [TOTAL_W-1:0] total;
   logic signed [TOTAL_W-1:0] total_bias;
   logic signed [TOTAL_W-1:0] total_shift;

   // gains are unsigned, widened by a zero so the multiply stays signed
   assign prod_p = $signed({1'b0, gains.p}) * err;
   assign prod_i = $signed({1'b0, gains.i}) * err_sum;
   assign prod_d = $signed({1'b0, gains.d}) * err_diff;

   assign total = TOTAL_W'(prod_p) + TOTAL_W'(prod_i) + TOTAL_W'(prod_d);

   // negative totals get a bias of one below the divisor so the shift rounds to zero
   assign total_bias  = total[TOTAL_W-1]
                      ? total + $signed(TOTAL_W'((1 << FRAC_BITS) - 1))
                      : total;
   assign total_shift = total_bias >>> FRAC_BITS;
   assign correction  = total_shift[CORR_W-1:0];

endmodule

`default_nettype wire

### verif/duty_checker.sv
// ----------------------------------------------------------------------------
// duty_checker
// watches the csr port and both channels, predicts each duty pair from the
// accepted position errors and compares it with the response that comes out
// ----------------------------------------------------------------------------
`default_nettype none

module duty_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [dpdc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dpdc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [dpdc_pkg::ERR_W-1:0]   req_position_error,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [dpdc_pkg::DUTY_W-1:0]         rsp_duty_left,
   input  logic [dpdc_pkg::DUTY_W-1:0]         rsp_duty_right,
   output int                                  failures,
   output int                                  pending_count
);
   import dpdc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DUTY_W-1:0] left;
      logic [DUTY_W-1:0] right;
   } duty_pair_type;

   csr_type                 settings;
   logic signed [ERR_W-1:0] integral_sum;
   logic signed [ERR_W-1:0] prior_error;
   duty_pair_type           expected_duties[$];

   // q.10 sum of the three terms, truncated toward zero
   function automatic longint side_correction(input gain_set_type gains,
                                              input longint e_val,
                                              input longint s_val,
                                              input longint d_val);
      longint total;
      total = longint'(gains.p) * e_val + longint'(gains.i) * s_val
            + longint'(gains.d) * d_val;
      return total / (longint'(1) << FRAC_BITS);
   endfunction

   function automatic logic [DUTY_W-1:0] limit_duty(input longint duty,
                                                    input logic [DUTY_W-1:0] ceiling);
      if (duty > longint'(ceiling)) begin
         return ceiling;
      end else if (duty <= 0) begin
         return DUTY_W'(1);
      end
      return duty[DUTY_W-1:0];
   endfunction

   function automatic duty_pair_type predict_duties(input logic signed [ERR_W-1:0] err);
      longint        e_val;
      longint        s_val;
      longint        d_val;
      longint        base_val;
      duty_pair_type duties;
      integral_sum = integral_sum + err;   // wraps at 8 bits
      e_val    = err;
      s_val    = integral_sum;
      d_val    = e_val - longint'(prior_error);
      base_val = longint'(settings.base_speed);
      duties.left  = limit_duty(base_val + side_correction(settings.left, e_val, s_val, d_val),
                                settings.max_speed);
      duties.right = limit_duty(base_val - side_correction(settings.right, e_val, s_val, d_val),
                                settings.max_speed);
      prior_error = err;
      return duties;
   endfunction

   always @(posedge clock) begin : watch
      duty_pair_type due;
      if (reset) begin
         settings.left       = '{p: RST_GAIN_P, i: RST_GAIN_I, d: RST_GAIN_D};
         settings.right      = '{p: RST_GAIN_P, i: RST_GAIN_I, d: RST_GAIN_D};
         settings.base_speed = RST_BASE;
         settings.max_speed  = RST_MAX;
         integral_sum        = '0;
         prior_error         = '0;
         expected_duties.delete();
         failures           <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_GAIN_P_LEFT:  settings.left.p      = csr_write_data;
               REG_GAIN_I_LEFT:  settings.left.i      = csr_write_data;
               REG_GAIN_D_LEFT:  settings.left.d      = csr_write_data;
               REG_GAIN_P_RIGHT: settings.right.p     = csr_write_data;
               REG_GAIN_I_RIGHT: settings.right.i     = csr_write_data;
               REG_GAIN_D_RIGHT: settings.right.d     = csr_write_data;
               REG_BASE_SPEED:   settings.base_speed  = csr_write_data;
               REG_MAX_SPEED:    settings.max_speed   = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_duties.size() == 0) begin
               $error("duty pair with no request outstanding: left %0d right %0d",
                      rsp_duty_left, rsp_duty_right);
               failures <= failures + 1;
            end else begin
               due = expected_duties.pop_front();
               if (rsp_duty_left !== due.left || rsp_duty_right !== due.right) begin
                  failures <= failures + 1;
               end
               if (rsp_duty_left !== due.left) begin
                  $error("duty_left: expected %0d, actual %0d", due.left, rsp_duty_left);
               end
               if (rsp_duty_right !== due.right) begin
                  $error("duty_right: expected %0d, actual %0d", due.right, rsp_duty_right);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_duties.push_back(predict_duties(req_position_error));
         end
      end
      pending_count <= expected_duties.size();
   end

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives position errors and gain settings into the differential pid
// controller with random pacing on both channels; duty_checker predicts and
// compares every duty pair, this module gives the verdict
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import dpdc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT    = 2000;   // cycles with no request or response moving
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ERRORS  = 300;
   localparam logic signed [ERR_W-1:0] ERR_MOST_POS = 8'h7F;
   localparam logic signed [ERR_W-1:0] ERR_MOST_NEG = 8'h80;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int   failures;
   int   pending_count;
   int   idle_cycles = 0;
   int   ready_hold  = 0;
   logic sender_gaps = 1'b0;   // random gaps between requests
   logic sink_stalls = 1'b0;   // random back-pressure on responses

   dpdc_req_if req_chan ();
   dpdc_rsp_if rsp_chan ();

   differential_pid_duty_controller dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   duty_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_chan.valid),
      .req_ready          (req_chan.ready),
      .req_position_error (req_chan.position_error),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_duty_left      (rsp_chan.duty_left),
      .rsp_duty_right     (rsp_chan.duty_right),
      .failures           (failures),
      .pending_count      (pending_count)
   );

   always #5 clock = ~clock;

   // response side pacing: mostly short holds, now and then a long stall
   always @(posedge clock) begin : sink_pacing
      int draw;
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (!sink_stalls) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         draw = $urandom_range(0, 99);
         if (draw < 60) begin
            rsp_chan.ready <= 1'b1;
            ready_hold     <= $urandom_range(0, 4);
         end else if (draw < 95) begin
            rsp_chan.ready <= 1'b0;
            ready_hold     <= $urandom_range(0, 3);
         end else begin
            rsp_chan.ready <= 1'b0;
            ready_hold     <= $urandom_range(10, 40);
         end
      end
   end

   // watchdog: ends the run if the channels stop moving
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // sender gap before the next request, zero when gaps are off
   function automatic int pick_gap();
      int draw;
      draw = $urandom_range(0, 99);
      if (!sender_gaps || draw < 65) begin
         return 0;
      end else if (draw < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // mostly near the line, often anywhere, sometimes the edge values
   function automatic logic signed [ERR_W-1:0] pick_error();
      int draw;
      int v;
      draw = $urandom_range(0, 99);
      if (draw < 50) begin
         v = int'($urandom_range(0, 32)) - 16;
      end else if (draw < 85) begin
         v = $urandom;
      end else begin
         case ($urandom_range(0, 4))
            0:       v = ERR_MOST_POS;
            1:       v = ERR_MOST_NEG;
            2:       v = -1;
            3:       v = 1;
            default: v = 0;
         endcase
      end
      return v[ERR_W-1:0];
   endfunction

   // style 0 realistic tuning, 1 anything in range, 2 corners only
   function automatic csr_type pick_settings(input int style);
      csr_type s;
      case (style)
         0: begin
            s.left       = '{p: GAIN_W'($urandom_range(0, 4096)),
                             i: GAIN_W'($urandom_range(0, 512)),
                             d: GAIN_W'($urandom_range(0, 16384))};
            s.right      = '{p: GAIN_W'($urandom_range(0, 4096)),
                             i: GAIN_W'($urandom_range(0, 512)),
                             d: GAIN_W'($urandom_range(0, 16384))};
            s.base_speed = DUTY_W'($urandom_range(0, 40000));
            s.max_speed  = DUTY_W'($urandom_range(20000, 65535));
         end
         1: begin
            s.left       = '{p: GAIN_W'($urandom), i: GAIN_W'($urandom),
                             d: GAIN_W'($urandom)};
            s.right      = '{p: GAIN_W'($urandom), i: GAIN_W'($urandom),
                             d: GAIN_W'($urandom)};
            s.base_speed = DUTY_W'($urandom);
            s.max_speed  = DUTY_W'($urandom_range(1, 65535));
         end
         default: begin
            s.left       = '{p: $urandom_range(0, 1) ? 16'hFFFF : 16'h0,
                             i: $urandom_range(0, 1) ? 16'hFFFF : 16'h0,
                             d: $urandom_range(0, 1) ? 16'hFFFF : 16'h0};
            s.right      = '{p: $urandom_range(0, 1) ? 16'hFFFF : 16'h0,
                             i: $urandom_range(0, 1) ? 16'hFFFF : 16'h0,
                             d: $urandom_range(0, 1) ? 16'hFFFF : 16'h0};
            s.base_speed = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
            s.max_speed  = $urandom_range(0, 1) ? 16'hFFFF : 16'h1;
         end
      endcase
      return s;
   endfunction

   // one request; valid stays high afterwards unless a gap follows
   task automatic offer_error(input logic signed [ERR_W-1:0] err);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.position_error <= err;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // stop sending and wait for every outstanding duty pair
   task automatic wait_for_duties();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // all eight registers, back to back; only while the pipeline is empty
   task automatic load_settings(input csr_type s);
      logic [CSR_DATA_W-1:0] values [REG_COUNT];
      values[REG_GAIN_P_LEFT]  = s.left.p;
      values[REG_GAIN_I_LEFT]  = s.left.i;
      values[REG_GAIN_D_LEFT]  = s.left.d;
      values[REG_GAIN_P_RIGHT] = s.right.p;
      values[REG_GAIN_I_RIGHT] = s.right.i;
      values[REG_GAIN_D_RIGHT] = s.right.d;
      values[REG_BASE_SPEED]   = s.base_speed;
      values[REG_MAX_SPEED]    = s.max_speed;
      for (int r = 0; r < REG_COUNT; r++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_INDEX_W'(r);
         csr_write_data   <= values[r];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      csr_type s;
      reset                   = 1'b1;
      csr_write_enable        = 1'b0;
      csr_index               = '0;
      csr_write_data          = '0;
      req_chan.valid          = 1'b0;
      req_chan.position_error = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset gains: zero, both extremes, a swing across the line
      offer_error('0);
      offer_error(ERR_MOST_POS);
      offer_error(ERR_MOST_NEG);
      offer_error(ERR_MOST_POS);
      offer_error(-8'sd1);
      offer_error(8'sd1);
      offer_error('0);
      wait_for_duties();

      // integral only, mid base: three full-scale steps wrap the accumulator
      s.left       = '{p: 16'h0, i: 16'hFFFF, d: 16'h0};
      s.right      = '{p: 16'h0, i: 16'hFFFF, d: 16'h0};
      s.base_speed = 16'h8000;
      s.max_speed  = 16'hFFFF;
      load_settings(s);
      offer_error(ERR_MOST_POS);
      offer_error(ERR_MOST_POS);
      offer_error(ERR_MOST_POS);
      offer_error(ERR_MOST_NEG);
      offer_error(ERR_MOST_NEG);
      wait_for_duties();

      // all gains full scale, full base, ceiling of one: every duty clamps
      s.left       = '{p: 16'hFFFF, i: 16'hFFFF, d: 16'hFFFF};
      s.right      = '{p: 16'hFFFF, i: 16'hFFFF, d: 16'hFFFF};
      s.base_speed = 16'hFFFF;
      s.max_speed  = 16'h1;
      load_settings(s);
      offer_error(ERR_MOST_NEG);
      offer_error(ERR_MOST_POS);
      offer_error('0);
      wait_for_duties();

      // zero base: one side drops to the floor, the other follows the correction
      s.base_speed = 16'h0;
      s.max_speed  = 16'hFFFF;
      load_settings(s);
      offer_error(ERR_MOST_POS);
      offer_error(ERR_MOST_NEG);
      offer_error(-8'sd1);
      offer_error('0);

      // random phases, each with fresh settings; the first runs flat out
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_duties();
         load_settings(pick_settings(phase % 3));
         sender_gaps <= (phase != 0) && (phase != 4);
         sink_stalls <= (phase != 0) && (phase != 3);
         for (int n = 0; n < PHASE_ERRORS; n++) begin
            // let the pipeline run dry part way through some phases
            if (n == PHASE_ERRORS / 2 && phase % 2 == 1) begin
               wait_for_duties();
            end
            offer_error(pick_error());
         end
      end

      wait_for_duties();
      repeat (4) @(posedge clock);   // anything late would show up by now
      if (failures == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
